[hw/rtl/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants, status codes and control types of the sorted timeout queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TIME_W      = 48;
  localparam int DUR_W       = 32;
  localparam int TAG_W       = 16;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_EXPIRED  = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic       accept_add;
    logic       accept_tick;
    logic       add_start;
    logic       shift;
    logic       put;
    logic       pop;
    logic       emit;
    logic       last;
    logic [1:0] status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic idx_one;
    logic later_dl;
    logic due;
    logic quota_left;
    logic have_pending;
  } stat_t;

endpackage

[hw/rtl/sorted_timeout_queue.sv]
// ----------------------------------------------------------------------------
// sorted_timeout_queue
// Timer event queue kept in deadline order, driven by add and tick commands.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge with start high and busy low. operation
// selects add (duration_ms, event_tag) or a one millisecond tick.
// Results appear for one cycle each with strobe high; last marks the final
// result of a command. The receiver cannot stall, so results never wait.
// Add: one result. Into an empty queue the command goes straight to the put
// state; otherwise the tail entry is read and compared, and the insertion
// walk moves each held event with a later deadline up one slot per cycle
// through the single port pair of the entry memory before the put. The
// strobe is registered from the put state. A full queue rejects the add
// through the reject state.
// Tick: the clock advances, then due events leave the head, one per cycle,
// earliest first, up to 16 per tick. The first strobe comes once the head
// is read and compared, and results then follow one per cycle; busy drops
// with the last result.
// The block takes no new command while busy, so commands do not overlap.
// Reset (rst, synchronous) empties the queue and sets the clock to zero;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_timeout_queue #(
  parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation,
  input  logic [stq_pkg::DUR_W-1:0]   duration_ms,
  input  logic [stq_pkg::TAG_W-1:0]   event_tag,
  output logic                        strobe,
  output logic [1:0]                  status,
  output logic [stq_pkg::TAG_W-1:0]   fired_tag,
  output logic [stq_pkg::TIME_W-1:0]  now_ms,
  output logic                        last
);

  stq_pkg::cmd_t  cmd;
  stq_pkg::stat_t stat;

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  stq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .duration_ms (duration_ms),
    .event_tag   (event_tag),
    .stat        (stat),
    .strobe      (strobe),
    .status      (status),
    .fired_tag   (fired_tag),
    .now_ms      (now_ms),
    .last        (last)
  );

endmodule

[hw/rtl/stq_datapath.sv]
// ----------------------------------------------------------------------------
// stq_datapath
// Circular entry memory kept in deadline order, clock, counters and result
// registers of the sorted timeout queue.
// ----------------------------------------------------------------------------
module stq_datapath #(
  parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  stq_pkg::cmd_t                cmd,
  input  logic [stq_pkg::DUR_W-1:0]    duration_ms,
  input  logic [stq_pkg::TAG_W-1:0]    event_tag,
  output stq_pkg::stat_t               stat,
  output logic                         strobe,
  output logic [1:0]                   status,
  output logic [stq_pkg::TAG_W-1:0]    fired_tag,
  output logic [stq_pkg::TIME_W-1:0]   now_ms,
  output logic                         last
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(stq_pkg::MAX_RESULTS + 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [NW-1:0] MAX_N = NW'(stq_pkg::MAX_RESULTS);

  stq_pkg::entry_t mem [QUEUE_DEPTH];
  stq_pkg::entry_t rd_q;
  stq_pkg::entry_t wr_data;

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic [NW-1:0] n;
  logic [stq_pkg::TIME_W-1:0] clock_ms;
  logic [stq_pkg::TIME_W-1:0] new_dl;
  logic [stq_pkg::TAG_W-1:0]  new_tag;
  logic [stq_pkg::TAG_W-1:0]  pending_tag;

  logic [AW-1:0] rd_off;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  // logical position to physical slot, offset always below the depth
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    priority if (cmd.add_start) begin
      rd_off = count[AW-1:0] - AW'(1);
    end else if (cmd.shift) begin
      rd_off = (idx == AW'(1)) ? '0 : idx - AW'(2);
    end else if (cmd.pop) begin
      rd_off = AW'(1);   // next head, seen after the pop
    end else begin
      rd_off = '0;
    end
  end

  assign rd_addr = phys(head, rd_off);
  assign wr_addr = phys(head, idx);
  assign wr_en   = cmd.put | cmd.shift;
  assign wr_data = cmd.put ? stq_pkg::entry_t'{deadline: new_dl, tag: new_tag} : rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      clock_ms <= '0;
      n        <= '0;
      strobe   <= 1'b0;
    end else begin
      if (cmd.accept_tick) begin
        clock_ms <= clock_ms + stq_pkg::TIME_W'(1);
        n        <= '0;
      end
      if (cmd.put) begin
        count <= count + CW'(1);
      end
      if (cmd.pop) begin
        head  <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
        count <= count - CW'(1);
        n     <= n + NW'(1);
      end
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_add) begin
      new_dl  <= clock_ms + stq_pkg::TIME_W'(duration_ms);
      new_tag <= event_tag;
      idx     <= count[AW-1:0];
    end else if (cmd.shift) begin
      idx <= idx - AW'(1);
    end
    if (cmd.pop) begin
      pending_tag <= rd_q.tag;
    end
    if (cmd.emit) begin
      status    <= cmd.status;
      fired_tag <= (cmd.status == stq_pkg::ST_EXPIRED) ? pending_tag : '0;
      now_ms    <= clock_ms;
      last      <= cmd.last;
    end
  end

  assign stat.count_zero   = (count == '0);
  assign stat.full         = (count == FULL_COUNT);
  assign stat.idx_one      = (idx == AW'(1));
  assign stat.later_dl     = (rd_q.deadline > new_dl);
  assign stat.due          = (count != '0) && (rd_q.deadline <= clock_ms);
  assign stat.quota_left   = (n < MAX_N);
  assign stat.have_pending = (n != '0);

endmodule

[hw/rtl/stq_ctrl.sv]
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer of the sorted timeout queue: insertion walk, expiry pops and
// result strobes.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           operation,
  input  stq_pkg::stat_t stat,
  output stq_pkg::cmd_t  cmd,
  output logic           busy
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ADD_RD   = 3'd1;
  localparam logic [2:0] S_ADD_CMP  = 3'd2;
  localparam logic [2:0] S_PUT      = 3'd3;
  localparam logic [2:0] S_REJECT   = 3'd4;
  localparam logic [2:0] S_TICK_RD  = 3'd5;
  localparam logic [2:0] S_TICK_CMP = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == stq_pkg::OP_ADD) begin
            if (stat.full) begin
              state_next = S_REJECT;
            end else begin
              cmd.accept_add = 1'b1;
              state_next     = stat.count_zero ? S_PUT : S_ADD_RD;
            end
          end else begin
            cmd.accept_tick = 1'b1;
            state_next      = S_TICK_RD;
          end
        end
      end
      S_ADD_RD: begin
        cmd.add_start = 1'b1;
        state_next    = S_ADD_CMP;
      end
      S_ADD_CMP: begin
        // move later entries up one slot, stop at the first one not later
        if (stat.later_dl) begin
          cmd.shift = 1'b1;
          if (stat.idx_one) begin
            state_next = S_PUT;
          end
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        cmd.emit   = 1'b1;
        cmd.status = stq_pkg::ST_ADDED;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_REJECT: begin
        cmd.emit   = 1'b1;
        cmd.status = stq_pkg::ST_REJECTED;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_TICK_RD: begin
        state_next = S_TICK_CMP;
      end
      S_TICK_CMP: begin
        // the popped tag goes out in the following cycle, once we know if it is last
        if (stat.due && stat.quota_left) begin
          cmd.pop = 1'b1;
          if (stat.have_pending) begin
            cmd.emit   = 1'b1;
            cmd.status = stq_pkg::ST_EXPIRED;
          end
        end else begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.status = stat.have_pending ? stq_pkg::ST_EXPIRED : stq_pkg::ST_NONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/stq_checker.sv]
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks of the sorted timeout queue, bound to the top level.
// ----------------------------------------------------------------------------
module stq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        strobe,
  input logic [1:0]                  status,
  input logic [stq_pkg::TAG_W-1:0]   fired_tag,
  input logic                        last
);

  // every accepted command raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // add results come alone and carry no tag
  a_add_single: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == stq_pkg::ST_ADDED || status == stq_pkg::ST_REJECTED)
      |-> last && fired_tag == '0)
    else $error("add result not single or tagged");

  // a quiet tick gives exactly one untagged beat
  a_none_single: assert property (@(posedge clk) disable iff (rst)
    strobe && status == stq_pkg::ST_NONE |-> last && fired_tag == '0)
    else $error("empty tick result malformed");

  // expiry beats of one tick follow back to back
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> status == stq_pkg::ST_EXPIRED ##1
      (strobe && status == stq_pkg::ST_EXPIRED))
    else $error("expiry burst broken");

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .status    (status),
  .fired_tag (fired_tag),
  .last      (last)
);

[verif/tb_sorted_timeout_queue.sv]
// ----------------------------------------------------------------------------
// tb_sorted_timeout_queue
// Self-checking bench for the sorted timeout queue: add and tick commands are
// driven through the start/busy handshake, and every strobed result is
// checked against a software copy of the deadline-ordered queue and clock.
// ----------------------------------------------------------------------------
module tb_sorted_timeout_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 400;
  localparam int RANDOM_BEATS = 360;
  localparam int TAIL_CYCLES  = 24;

  typedef struct packed {
    logic [1:0]                 status;
    logic [stq_pkg::TAG_W-1:0]  tag;
    logic [stq_pkg::TIME_W-1:0] now;
    logic                       last;
  } outcome_t;

  class timer_scoreboard;
    stq_pkg::entry_t            held_events[$];
    logic [stq_pkg::TIME_W-1:0] clock_ms;
    outcome_t                   owed_results[$];
    int                         n_failures;

    function new();
      clock_ms   = '0;
      n_failures = 0;
    endfunction

    // expected results of one accepted command beat
    function void log_command(logic op, logic [stq_pkg::DUR_W-1:0] dur,
                              logic [stq_pkg::TAG_W-1:0] tag);
      outcome_t        o;
      stq_pkg::entry_t e;
      int              pos;
      int              n;
      if (op == stq_pkg::OP_ADD) begin
        o.tag  = '0;
        o.now  = clock_ms;
        o.last = 1'b1;
        if (held_events.size() >= stq_pkg::QUEUE_DEPTH) begin
          o.status = stq_pkg::ST_REJECTED;
        end else begin
          e.deadline = clock_ms + {{(stq_pkg::TIME_W-stq_pkg::DUR_W){1'b0}}, dur};
          e.tag      = tag;
          pos = 0;
          // equal deadlines keep arrival order
          while (pos < held_events.size() && held_events[pos].deadline <= e.deadline)
            pos++;
          held_events.insert(pos, e);
          o.status = stq_pkg::ST_ADDED;
        end
        owed_results.push_back(o);
      end else begin
        clock_ms = clock_ms + 48'd1;
        n = 0;
        while (n < stq_pkg::MAX_RESULTS && held_events.size() > 0 &&
               held_events[0].deadline <= clock_ms) begin
          e = held_events.pop_front();
          n++;
          o.status = stq_pkg::ST_EXPIRED;
          o.tag    = e.tag;
          o.now    = clock_ms;
          o.last   = !(n < stq_pkg::MAX_RESULTS && held_events.size() > 0 &&
                       held_events[0].deadline <= clock_ms);
          owed_results.push_back(o);
        end
        if (n == 0) begin
          o.status = stq_pkg::ST_NONE;
          o.tag    = '0;
          o.now    = clock_ms;
          o.last   = 1'b1;
          owed_results.push_back(o);
        end
      end
    endfunction

    function void check_result(logic [1:0] st, logic [stq_pkg::TAG_W-1:0] tag,
                               logic [stq_pkg::TIME_W-1:0] now, logic lst);
      outcome_t want;
      if (owed_results.size() == 0) begin
        n_failures++;
        if (n_failures <= 10)
          $display("unexpected result: status=%0d tag=%h now=%0d last=%0b",
                   st, tag, now, lst);
        return;
      end
      want = owed_results.pop_front();
      if (st !== want.status || tag !== want.tag || now !== want.now ||
          lst !== want.last) begin
        n_failures++;
        if (n_failures <= 10)
          $display({"mismatch: expected status=%0d tag=%h now=%0d last=%0b,",
                    " got status=%0d tag=%h now=%0d last=%0b"},
                   want.status, want.tag, want.now, want.last, st, tag, now, lst);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       operation = stq_pkg::OP_TICK;
  logic [stq_pkg::DUR_W-1:0]  duration_ms = '0;
  logic [stq_pkg::TAG_W-1:0]  event_tag = '0;
  logic                       strobe;
  logic [1:0]                 status;
  logic [stq_pkg::TAG_W-1:0]  fired_tag;
  logic [stq_pkg::TIME_W-1:0] now_ms;
  logic                       last;

  timer_scoreboard board = new();
  bit              steady = 1'b0;
  int              idle_cycles = 0;

  sorted_timeout_queue i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .duration_ms (duration_ms),
    .event_tag   (event_tag),
    .strobe      (strobe),
    .status      (status),
    .fired_tag   (fired_tag),
    .now_ms      (now_ms),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && strobe)
      board.check_result(status, fired_tag, now_ms, last);
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_cmd(logic op, logic [stq_pkg::DUR_W-1:0] dur,
                          logic [stq_pkg::TAG_W-1:0] tag);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    operation   <= op;
    duration_ms <= dur;
    event_tag   <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.log_command(op, dur, tag);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [stq_pkg::DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      return $urandom();
    else if (r < 10)
      return $urandom_range(16, 60);
    return $urandom_range(0, 12);
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill with equal deadlines, then one add too many
    for (int i = 0; i < stq_pkg::QUEUE_DEPTH; i++)
      send_cmd(stq_pkg::OP_ADD, '0,
               (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom()));
    send_cmd(stq_pkg::OP_ADD, '0, 16'h1234);
    // a full burst of expiries, then a tick with nothing due
    send_cmd(stq_pkg::OP_TICK, '0, '0);
    send_cmd(stq_pkg::OP_TICK, '0, '0);
    // later deadline first so the insertion walk has to move it
    send_cmd(stq_pkg::OP_ADD, 32'd3, 16'hA5A5);
    send_cmd(stq_pkg::OP_ADD, 32'd1, 16'h5A5A);
    send_cmd(stq_pkg::OP_ADD, 32'd1, 16'h0F0F);
    repeat (3) send_cmd(stq_pkg::OP_TICK, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(stq_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    wait_drained();

    for (int k = 0; k < RANDOM_BEATS; k++) begin
      steady = (k % 60) < 15;
      if (k == RANDOM_BEATS / 2)
        wait_drained();
      if ($urandom_range(0, 1) == 1)
        send_cmd(stq_pkg::OP_ADD, pick_duration(), 16'($urandom()));
      else
        send_cmd(stq_pkg::OP_TICK, $urandom(), 16'($urandom()));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.owed_results.size() != 0)
      board.n_failures++;
    if (board.n_failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
